FILE: rtl/mnst_pkg.sv
// shared types and constants for the midi note state tracker
`default_nettype none

package mnst_pkg;

  localparam int unsigned KeyW    = 7;
  localparam int unsigned NumKeys = 1 << KeyW;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned ChanW   = 4;

  typedef logic [KeyW-1:0]  key_t;
  typedef logic [ByteW-1:0] byte_t;
  typedef logic [ChanW-1:0] chan_t;

  typedef enum logic [2:0] {
    PhIdle   = 3'd0,
    PhOffKey = 3'd1,
    PhOnKey  = 3'd2,
    PhOnVel  = 3'd3,
    PhCtlNum = 3'd4,
    PhCtlVal = 3'd5
  } phase_e;

  // message kind, status bits 6..4
  localparam logic [2:0] KindNoteOff = 3'h0;
  localparam logic [2:0] KindNoteOn  = 3'h1;
  localparam logic [2:0] KindCtl     = 3'h3;

  localparam byte_t StatusReset = 8'hFF;

  localparam key_t CtlWaveform = 7'h3F;
  localparam key_t CtlPedal    = 7'h40;
  localparam key_t CtlAllOffLo = 7'h78;
  localparam key_t CtlAllOffHi = 7'h7A;

endpackage

`default_nettype wire

FILE: rtl/mnst_in_if.sv
// request channel carrying midi bytes and key queries
`default_nettype none

interface mnst_in_if;
  logic                 valid;
  logic                 ready;
  logic                 mode;
  mnst_pkg::byte_t      midi_byte;
  mnst_pkg::key_t       query_key;

  modport source (output valid, output mode, output midi_byte, output query_key,
                  input ready);
  modport sink   (input valid, input mode, input midi_byte, input query_key,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/mnst_out_if.sv
// result channel carrying key, pedal and waveform state
`default_nettype none

interface mnst_out_if;
  logic                 valid;
  logic                 ready;
  mnst_pkg::key_t       key_level;
  mnst_pkg::key_t       pedal_level;
  mnst_pkg::key_t       waveform_value;
  logic                 waveform_set;
  logic                 all_off_event;

  modport source (output valid, output key_level, output pedal_level,
                  output waveform_value, output waveform_set, output all_off_event,
                  input ready);
  modport sink   (input valid, input key_level, input pedal_level,
                  input waveform_value, input waveform_set, input all_off_event,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/midi_note_state_tracker_top.sv
// Usage:
//   in_i takes one request per handshake: either a received midi byte (mode 0)
//   or a query of one key's level (mode 1). out_o returns exactly one result
//   per request: the queried key's level, pedal, waveform value and flag, and
//   whether the byte cleared all notes. cfg_we_i/cfg_wdata_i set the listen
//   channel; the user must do so only while the block is idle, which the
//   block itself does not enforce. A result passes the note table read
//   register, then the result register. One request is accepted every cycle
//   while out_o is not stalled; that rate is set by the single write port and
//   registered read port of the note table, both used once per request.
//   Reset clears the parser, pedal, waveform state and a valid bit for each
//   of the 128 keys at once, so the table reads as zero with no clearing
//   pass; the same valid bits clear the table on an all-notes-off.
//   When the receiver stalls the result register holds, one more request is
//   taken into the read stage, and in_i.ready then drops until out_o drains.
`default_nettype none

module midi_note_state_tracker_top (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              cfg_we_i,
  input  mnst_pkg::chan_t  cfg_wdata_i,
  mnst_in_if.sink          in_i,
  mnst_out_if.source       out_o
);
  import mnst_pkg::*;

  chan_t          chan_q;
  phase_e         phase_q, phase_d;
  key_t           held_q, held_d;
  key_t           pedal_q, pedal_d;
  key_t           wave_q, wave_d;
  logic           wave_set_q, wave_set_d;
  logic [NumKeys-1:0] valid_q, valid_d;

  key_t           mem [NumKeys];

  logic           accept, take, s2_free;
  key_t           data7;
  logic           is_status;
  logic           we, kill, clear;
  key_t           waddr, wdata;

  // read stage
  logic           s1_valid_q;
  key_t           s1_rd_q, s1_bdata_q, s1_pedal_q, s1_wave_q;
  logic           s1_kvalid_q, s1_byp_q, s1_wave_set_q, s1_clear_q;
  key_t           s1_key;

  // result stage
  logic           out_valid_q;
  key_t           out_key_q, out_pedal_q, out_wave_q;
  logic           out_wave_set_q, out_clear_q;

  assign s2_free    = !out_valid_q || out_o.ready;
  assign in_i.ready = !s1_valid_q || s2_free;
  assign accept     = in_i.valid && in_i.ready;
  assign take       = accept && !in_i.mode;
  assign data7      = in_i.midi_byte[KeyW-1:0];
  assign is_status  = in_i.midi_byte[ByteW-1] && (in_i.midi_byte[ChanW-1:0] == chan_q);

  // parser next state
  always_comb begin
    phase_d = phase_q;
    held_d  = held_q;
    if (take) begin
      case (phase_q)
        PhOffKey: phase_d = PhIdle;
        PhOnKey: begin
          held_d  = data7;
          phase_d = PhOnVel;
        end
        PhOnVel: phase_d = PhIdle;
        PhCtlNum: begin
          held_d  = data7;
          phase_d = PhCtlVal;
        end
        PhCtlVal: phase_d = PhIdle;
        default: begin
          // idle, and the unreachable codes behave as idle
          phase_d = PhIdle;
          if (is_status) begin
            case (in_i.midi_byte[6:4])
              KindNoteOff: phase_d = PhOffKey;
              KindNoteOn:  phase_d = PhOnKey;
              KindCtl:     phase_d = PhCtlNum;
              default:     phase_d = PhIdle;
            endcase
          end
        end
      endcase
    end
  end

  // parser actions
  always_comb begin
    we         = 1'b0;
    kill       = 1'b0;
    clear      = 1'b0;
    waddr      = data7;
    wdata      = data7;
    pedal_d    = pedal_q;
    wave_d     = wave_q;
    wave_set_d = wave_set_q;
    if (take) begin
      case (phase_q)
        PhOffKey: kill = 1'b1;
        PhOnKey:  we = 1'b0;
        PhOnVel: begin
          we    = 1'b1;
          waddr = held_q;
        end
        PhCtlNum: we = 1'b0;
        PhCtlVal: begin
          if (held_q == CtlWaveform) begin
            wave_d     = data7;
            wave_set_d = 1'b1;
          end else if (held_q == CtlPedal) begin
            pedal_d = data7;
          end else if (held_q >= CtlAllOffLo && held_q <= CtlAllOffHi) begin
            clear = 1'b1;
          end
        end
        default: clear = is_status && (in_i.midi_byte == StatusReset);
      endcase
    end
    if (clear) begin
      pedal_d = '0;
    end
  end

  // a key reads as zero unless its valid bit is set
  always_comb begin
    valid_d = valid_q;
    if (clear) begin
      valid_d = '0;
    end else if (we) begin
      valid_d[waddr] = 1'b1;
    end else if (kill) begin
      valid_d[waddr] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_q     <= '0;
      phase_q    <= PhIdle;
      held_q     <= '0;
      pedal_q    <= '0;
      wave_q     <= '0;
      wave_set_q <= 1'b0;
      valid_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        chan_q <= cfg_wdata_i;
      end
      phase_q    <= phase_d;
      held_q     <= held_d;
      pedal_q    <= pedal_d;
      wave_q     <= wave_d;
      wave_set_q <= wave_set_d;
      valid_q    <= valid_d;
    end
  end

  // note table
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (accept) begin
      s1_rd_q <= mem[in_i.query_key];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_kvalid_q   <= valid_d[in_i.query_key];
      s1_byp_q      <= we && (waddr == in_i.query_key);
      s1_bdata_q    <= wdata;
      s1_pedal_q    <= pedal_d;
      s1_wave_q     <= wave_d;
      s1_wave_set_q <= wave_set_d;
      s1_clear_q    <= clear;
    end
  end

  always_comb begin
    if (!s1_kvalid_q) begin
      s1_key = '0;
    end else if (s1_byp_q) begin
      s1_key = s1_bdata_q;
    end else begin
      s1_key = s1_rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s2_free) begin
        s1_valid_q <= 1'b0;
      end
      if (s2_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_free && s1_valid_q) begin
      out_key_q      <= s1_key;
      out_pedal_q    <= s1_pedal_q;
      out_wave_q     <= s1_wave_q;
      out_wave_set_q <= s1_wave_set_q;
      out_clear_q    <= s1_clear_q;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.key_level      = out_key_q;
  assign out_o.pedal_level    = out_pedal_q;
  assign out_o.waveform_value = out_wave_q;
  assign out_o.waveform_set   = out_wave_set_q;
  assign out_o.all_off_event  = out_clear_q;

`ifndef ASSERT_OFF
  a_clear_wipes_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear |=> (valid_q == '0) && (pedal_q == '0))
    else $error("all-notes-off did not clear table and pedal");

  a_query_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.mode) |=> $stable(phase_q) && $stable(pedal_q) && $stable(valid_q)
      && $stable(wave_q) && $stable(held_q))
    else $error("query request changed parser state");

  a_full_pipe_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && !out_o.ready) |-> !in_i.ready)
    else $error("request taken with both stages full and stalled");

  a_stage_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s2_free) |=> out_valid_q)
    else $error("read stage result lost on its way to output");

  a_no_action_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !take |-> !we && !kill && !clear)
    else $error("table action without an accepted midi byte");
`endif

endmodule

`default_nettype wire

FILE: sim/midi_note_state_tracker_top_tb.sv
// self-checking testbench for the midi note state tracker: random midi streams and key queries
module midi_note_state_tracker_top_tb;
  import mnst_pkg::*;

  localparam int unsigned SettleCycles = 4;
  localparam int unsigned LongHold     = 70;
  localparam int unsigned HoldAtA      = 150;
  localparam int unsigned HoldAtB      = 420;
  localparam int unsigned CycleLimit   = 400_000;
  localparam int unsigned RandPhases   = 6;
  localparam int unsigned PhaseReqs    = 72;

  localparam logic ModeByte  = 1'b0;
  localparam logic ModeQuery = 1'b1;

  typedef enum logic {StimReq, StimSetChan} stim_kind_e;

  typedef struct {
    stim_kind_e  kind;
    logic        mode;
    byte_t       midi_byte;
    key_t        query_key;
    chan_t       chan;
    int unsigned gap;
  } stim_t;

  typedef struct packed {
    key_t key_level;
    key_t pedal_level;
    key_t waveform_value;
    logic waveform_set;
    logic all_off_event;
  } tracker_res_t;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  cfg_we_i;
  chan_t cfg_wdata_i;

  mnst_in_if  req_if ();
  mnst_out_if res_if ();

  midi_note_state_tracker_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (req_if),
    .out_o      (res_if)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // predictor state
  key_t   lvl_tab [NumKeys];
  key_t   pedal_val;
  key_t   wave_val;
  logic   wave_seen;
  phase_e parse_ph;
  key_t   held_num;
  chan_t  listen_chan;

  stim_t        pending_q [$];
  tracker_res_t expected_q [$];

  int unsigned send_calm, recv_calm;
  int unsigned n_planned, n_taken, n_results, n_all_off, n_settings, n_errors;
  int unsigned send_wait, settle_cnt, recv_wait, hold_len, cycle_cnt;
  logic         cfg_we_nxt;
  stim_t        head;
  tracker_res_t want_res;

  function automatic void clear_notes();
    foreach (lvl_tab[k]) lvl_tab[k] = '0;
    pedal_val = '0;
  endfunction

  function automatic tracker_res_t track_request(logic mode, byte_t b, key_t qk);
    tracker_res_t r;
    key_t         d;
    logic         cleared;
    cleared = 1'b0;
    d       = b[6:0];
    if (mode == ModeByte) begin
      case (parse_ph)
        PhOffKey: begin
          lvl_tab[d] = '0;
          parse_ph   = PhIdle;
        end
        PhOnKey: begin
          held_num = d;
          parse_ph = PhOnVel;
        end
        PhOnVel: begin
          lvl_tab[held_num] = d;
          parse_ph          = PhIdle;
        end
        PhCtlNum: begin
          held_num = d;
          parse_ph = PhCtlVal;
        end
        PhCtlVal: begin
          if (held_num == CtlWaveform) begin
            wave_val  = d;
            wave_seen = 1'b1;
          end else if (held_num == CtlPedal) begin
            pedal_val = d;
          end else if (held_num >= CtlAllOffLo && held_num <= CtlAllOffHi) begin
            clear_notes();
            cleared = 1'b1;
          end
          parse_ph = PhIdle;
        end
        default: begin
          parse_ph = PhIdle;
          // only status bytes on the listen channel start a message
          if (b[7] && b[3:0] == listen_chan) begin
            if (b == StatusReset) begin
              clear_notes();
              cleared = 1'b1;
            end
            case (b[6:4])
              KindNoteOff: parse_ph = PhOffKey;
              KindNoteOn:  parse_ph = PhOnKey;
              KindCtl:     parse_ph = PhCtlNum;
              default:     parse_ph = PhIdle;
            endcase
          end
        end
      endcase
    end
    r.key_level      = lvl_tab[qk];
    r.pedal_level    = pedal_val;
    r.waveform_value = wave_val;
    r.waveform_set   = wave_seen;
    r.all_off_event  = cleared;
    return r;
  endfunction

  // mostly short waits, now and then a run of back-to-back requests
  function automatic int unsigned draw_wait(inout int unsigned calm_left);
    if (calm_left != 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm_left = $urandom_range(10, 40);
      return 0;
    end
    if ($urandom_range(0, 2) == 0) return $urandom_range(0, 18);
    return $urandom_range(0, 1);
  endfunction

  function automatic void queue_req(logic mode, byte_t b, key_t qk);
    stim_t s;
    s.kind      = StimReq;
    s.mode      = mode;
    s.midi_byte = b;
    s.query_key = qk;
    s.chan      = '0;
    s.gap       = draw_wait(send_calm);
    pending_q.push_back(s);
    n_planned++;
  endfunction

  function automatic void queue_byte(byte_t b, key_t qk);
    queue_req(ModeByte, b, qk);
  endfunction

  function automatic void queue_query(key_t qk);
    queue_req(ModeQuery, byte_t'($urandom_range(0, 255)), qk);
  endfunction

  function automatic void queue_cfg(chan_t ch);
    stim_t s;
    s.kind      = StimSetChan;
    s.mode      = ModeByte;
    s.midi_byte = '0;
    s.query_key = '0;
    s.chan      = ch;
    s.gap       = 0;
    pending_q.push_back(s);
  endfunction

  // data byte, sometimes with bit 7 set inside the message
  function automatic byte_t as_data(key_t v);
    return {($urandom_range(0, 7) == 0), v};
  endfunction

  // one random message or stray byte; returns how many requests count as useful
  function automatic int unsigned queue_message(chan_t ch);
    key_t        k;
    key_t        num;
    chan_t       c;
    int unsigned pick;
    int unsigned useful;
    k    = key_t'($urandom_range(0, 127));
    c    = ($urandom_range(0, 9) == 0) ? ch ^ chan_t'($urandom_range(1, 15)) : ch;
    pick = $urandom_range(0, 99);
    useful = 0;
    if (pick < 35) begin
      queue_byte({1'b1, KindNoteOn, c}, k);
      queue_byte(as_data(k), k);
      queue_byte(as_data(key_t'($urandom_range(0, 127))), k);
      useful = 3;
    end else if (pick < 50) begin
      queue_byte({1'b1, KindNoteOff, c}, k);
      queue_byte(as_data(k), k);
      useful = 2;
    end else if (pick < 70) begin
      case ($urandom_range(0, 7))
        0, 1:    num = CtlWaveform;
        2, 3:    num = CtlPedal;
        4:       num = key_t'($urandom_range(CtlAllOffLo, CtlAllOffHi));
        5:       num = $urandom_range(0, 1) ? key_t'(CtlAllOffLo - 1) : key_t'(CtlAllOffHi + 1);
        default: num = key_t'($urandom_range(0, 127));
      endcase
      queue_byte({1'b1, KindCtl, c}, k);
      queue_byte(as_data(num), k);
      queue_byte(as_data(key_t'($urandom_range(0, 127))), k);
      useful = 3;
    end else if (pick < 75) begin
      queue_byte(StatusReset, k);
      useful = (ch == 4'hF) ? 1 : 0;
    end else if (pick < 88) begin
      queue_query(k);
      useful = 1;
    end else begin
      // stray byte: ignored, or it starts a message that the next one breaks
      queue_byte(byte_t'($urandom_range(0, 255)), k);
    end
    return (c == ch) ? useful : 0;
  endfunction

  function automatic void check_field(string name, key_t want, key_t got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid     <= 1'b0;
      req_if.mode      <= ModeByte;
      req_if.midi_byte <= '0;
      req_if.query_key <= '0;
      cfg_we_i         <= 1'b0;
      cfg_wdata_i      <= '0;
      send_wait        <= 0;
      settle_cnt       <= 0;
    end else begin
      cfg_we_nxt = 1'b0;
      if (req_if.valid && req_if.ready) begin
        expected_q.push_back(track_request(req_if.mode, req_if.midi_byte, req_if.query_key));
        n_taken++;
      end
      if (req_if.valid && !req_if.ready) begin
        // request still on offer
      end else if (send_wait != 0) begin
        req_if.valid <= 1'b0;
        send_wait    <= send_wait - 1;
      end else if (pending_q.size() == 0) begin
        req_if.valid <= 1'b0;
      end else if (pending_q[0].kind == StimReq) begin
        head = pending_q.pop_front();
        req_if.valid     <= 1'b1;
        req_if.mode      <= head.mode;
        req_if.midi_byte <= head.midi_byte;
        req_if.query_key <= head.query_key;
        send_wait        <= head.gap;
      end else begin
        // channel change: wait for every result and for settle_cnt to reach SettleCycles
        req_if.valid <= 1'b0;
        if (expected_q.size() != 0) begin
          settle_cnt <= 0;
        end else if (settle_cnt < SettleCycles) begin
          settle_cnt <= settle_cnt + 1;
        end else begin
          head = pending_q.pop_front();
          settle_cnt  <= 0;
          cfg_we_nxt  = 1'b1;
          cfg_wdata_i <= head.chan;
          listen_chan = head.chan;
          n_settings++;
        end
      end
      cfg_we_i <= cfg_we_nxt;
    end
  end

  // result monitor and checker
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      recv_wait    <= 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (expected_q.size() == 0) begin
          $error("result with no request outstanding");
          n_errors++;
        end else begin
          want_res = expected_q.pop_front();
          check_field("key_level", want_res.key_level, res_if.key_level);
          check_field("pedal_level", want_res.pedal_level, res_if.pedal_level);
          check_field("waveform_value", want_res.waveform_value, res_if.waveform_value);
          check_field("waveform_set", key_t'(want_res.waveform_set),
                      key_t'(res_if.waveform_set));
          check_field("all_off_event", key_t'(want_res.all_off_event),
                      key_t'(res_if.all_off_event));
          if (want_res.all_off_event) n_all_off++;
        end
        n_results++;
        // long hold-offs so the block backs up and drops ready
        if (n_results == HoldAtA || n_results == HoldAtB) hold_len = LongHold;
        else hold_len = draw_wait(recv_calm);
        res_if.ready <= (hold_len == 0);
        recv_wait    <= hold_len;
      end else if (recv_wait != 0) begin
        res_if.ready <= (recv_wait == 1);
        recv_wait    <= recv_wait - 1;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CycleLimit) begin
      $display("midi_note_state_tracker_top: mismatch");
      $finish;
    end
  end

  initial begin
    chan_t       phase_chan [RandPhases];
    int unsigned counted;
    req_if.valid     = 1'b0;
    req_if.mode      = ModeByte;
    req_if.midi_byte = '0;
    req_if.query_key = '0;
    res_if.ready     = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_wdata_i      = '0;
    clear_notes();
    wave_val    = '0;
    wave_seen   = 1'b0;
    parse_ph    = PhIdle;
    held_num    = '0;
    listen_chan = '0;

    // directed part on channel 0
    queue_cfg(4'd0);
    queue_byte({1'b0, CtlPedal}, 7'd0);
    queue_byte({1'b1, KindNoteOn, 4'd3}, 7'd0);
    queue_byte({1'b1, KindNoteOn, 4'd0}, 7'd0);
    queue_byte(8'h00, 7'd0);
    queue_byte(8'h7F, 7'd0);
    queue_byte({1'b1, KindNoteOn, 4'd0}, 7'd127);
    queue_byte(8'hFF, 7'd127);
    queue_byte(8'h81, 7'd127);
    queue_query(7'd127);
    queue_byte({1'b1, KindNoteOff, 4'd0}, 7'd0);
    queue_byte(8'h80, 7'd0);
    queue_byte({1'b1, KindCtl, 4'd0}, 7'd5);
    queue_byte({1'b0, CtlWaveform}, 7'd5);
    queue_byte(8'h7F, 7'd5);
    queue_byte({1'b1, KindCtl, 4'd0}, 7'd5);
    queue_byte({1'b0, CtlPedal}, 7'd5);
    queue_byte(8'h55, 7'd5);
    queue_byte({1'b1, KindCtl, 4'd0}, 7'd5);
    queue_byte(8'h11, 7'd5);
    queue_byte(8'h22, 7'd5);
    // status kinds the block does not handle
    for (int kd = 0; kd < 8; kd++)
      if (3'(kd) != KindNoteOff && 3'(kd) != KindNoteOn && 3'(kd) != KindCtl)
        queue_byte({1'b1, 3'(kd), 4'd0}, 7'd127);
    queue_byte({1'b1, KindCtl, 4'd0}, 7'd127);
    queue_byte({1'b0, CtlAllOffHi}, 7'd127);
    queue_byte(8'h00, 7'd127);
    // reset status only counts on channel 15
    queue_cfg(4'hF);
    queue_byte({1'b1, KindNoteOn, 4'hF}, 7'd60);
    queue_byte(8'h3C, 7'd60);
    queue_byte(8'h40, 7'd60);
    queue_byte(StatusReset, 7'd60);

    phase_chan[0] = 4'hF;
    phase_chan[1] = 4'd0;
    phase_chan[2] = chan_t'($urandom_range(0, 15));
    phase_chan[3] = 4'd7;
    phase_chan[4] = chan_t'($urandom_range(0, 15));
    phase_chan[5] = 4'hF;
    foreach (phase_chan[p]) begin
      queue_cfg(phase_chan[p]);
      counted = 0;
      while (counted < PhaseReqs) counted += queue_message(phase_chan[p]);
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    while (n_taken != n_planned || expected_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("sent %0d requests across %0d listen-channel settings", n_taken, n_settings);
    $display("checked %0d results, %0d of them clearing all notes", n_results, n_all_off);
    if (n_errors == 0) begin
      $display("midi_note_state_tracker_top: match");
    end else begin
      $display("midi_note_state_tracker_top: mismatch");
    end
    $finish;
  end

endmodule
